// ===== rtl/keyed_slot_pool_allocator_macros.svh =====
// assertion macros for the keyed slot pool allocator
// no dependencies; taken in by the rtl files that carry assertions
`ifndef KEYED_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define KEYED_SLOT_POOL_ALLOCATOR_MACROS_SVH

// condition implies consequence in the same cycle
`define KSPA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define KSPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/kspa_pkg.sv =====
// shared constants for the keyed slot pool allocator
// no dependencies
`default_nettype none

package kspa_pkg;

   // pool geometry
   localparam int POOL_SLOTS = 64;
   localparam int IDX_W      = $clog2(POOL_SLOTS);
   localparam int COUNT_W    = $clog2(POOL_SLOTS + 1);

   // item field widths
   localparam int OP_W     = 3;
   localparam int KEY_W    = 64;
   localparam int SLOT_IN_W = 7;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 6;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE       = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND       = 3'd2;
   localparam logic [OP_W-1:0] OP_GET_CREATE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/keyed_slot_pool_allocator.sv =====
// keyed slot pool allocator: used bits, key memory and scan sequencer
// depends on kspa_pkg and keyed_slot_pool_allocator_macros.svh
`default_nettype none

// The pool holds 64 slots, each with a used bit and a 64-bit key. One item is
// handled at a time: req_stall is high from acceptance until the result has been
// loaded into the output register, and a new item may be taken while that result
// still waits on rsp_stall. Free, clear and unused operation codes go from
// acceptance straight to the done state without a scan. Allocate, find and
// get-or-create walk the slots in order through one key compare fed by the key
// memory's single read port, one slot per cycle; an item stops at the slot that
// settles it, and a find or get-or-create that misses walks every slot. The key
// memory needs no clearing pass: only keys of used slots are ever compared, and
// each is written when its slot is claimed.

`include "keyed_slot_pool_allocator_macros.svh"

module keyed_slot_pool_allocator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [kspa_pkg::OP_W-1:0]          req_operation,
   input  wire logic [kspa_pkg::KEY_W-1:0]         req_key,
   input  wire logic [kspa_pkg::SLOT_IN_W-1:0]     req_slot_index,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [kspa_pkg::STATUS_W-1:0]           rsp_status,
   output logic [kspa_pkg::SLOT_W-1:0]             rsp_slot,
   output logic                                    rsp_created,
   output logic [kspa_pkg::COUNT_W-1:0]            rsp_used_count
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [kspa_pkg::OP_W-1:0]         op_ff, op_in;
   logic [kspa_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [kspa_pkg::SLOT_IN_W-1:0]    index_ff, index_in;
   logic [kspa_pkg::IDX_W-1:0]        scan_addr_ff, scan_addr_in;
   logic                              cmp_valid_ff, cmp_valid_in;
   logic [kspa_pkg::IDX_W-1:0]        cmp_slot_ff, cmp_slot_in;
   logic                              found_ff, found_in;
   logic [kspa_pkg::IDX_W-1:0]        found_slot_ff, found_slot_in;
   logic                              free_ok_ff, free_ok_in;
   logic [kspa_pkg::IDX_W-1:0]        free_slot_ff, free_slot_in;
   logic [kspa_pkg::POOL_SLOTS-1:0]   used_ff, used_in;
   logic [kspa_pkg::COUNT_W-1:0]      count_ff, count_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [kspa_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [kspa_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                              rsp_created_ff, rsp_created_in;

   // key memory ports
   logic [kspa_pkg::KEY_W-1:0]        key_mem [kspa_pkg::POOL_SLOTS];
   logic [kspa_pkg::KEY_W-1:0]        rd_key_ff;
   logic                              mem_we;
   logic [kspa_pkg::IDX_W-1:0]        mem_waddr;
   logic [kspa_pkg::KEY_W-1:0]        mem_wdata;

   // compare stage signals
   logic                              slot_used;
   logic                              slot_hit;
   logic                              scan_last;
   logic                              scan_stop;
   logic [kspa_pkg::IDX_W-1:0]        free_idx;
   logic                              out_free;

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_created      = rsp_created_ff;
   assign rsp_used_count   = count_ff;

   // shared key compare on the slot read last cycle
   assign slot_used = used_ff[cmp_slot_ff];
   assign slot_hit  = slot_used && (rd_key_ff == key_ff);
   assign scan_last = (cmp_slot_ff == kspa_pkg::IDX_W'(kspa_pkg::POOL_SLOTS - 1));
   assign scan_stop = scan_last
                    || ((op_ff == kspa_pkg::OP_ALLOC) && !slot_used)
                    || ((op_ff != kspa_pkg::OP_ALLOC) && slot_hit);

   assign free_idx = index_ff[kspa_pkg::IDX_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer and pool update
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      index_in       = index_ff;
      scan_addr_in   = scan_addr_ff;
      cmp_valid_in   = cmp_valid_ff;
      cmp_slot_in    = cmp_slot_ff;
      found_in       = found_ff;
      found_slot_in  = found_slot_ff;
      free_ok_in     = free_ok_ff;
      free_slot_in   = free_slot_ff;
      used_in        = used_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_created_in = rsp_created_ff;
      mem_we         = 1'b0;
      mem_waddr      = free_slot_ff;
      mem_wdata      = '0;

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in        = req_operation;
               key_in       = req_key;
               index_in     = req_slot_index;
               scan_addr_in = '0;
               cmp_valid_in = 1'b0;
               found_in     = 1'b0;
               free_ok_in   = 1'b0;
               if (req_operation inside {kspa_pkg::OP_ALLOC, kspa_pkg::OP_FIND,
                                         kspa_pkg::OP_GET_CREATE}) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // issue one key read per cycle, compare it the cycle after
            scan_addr_in = scan_addr_ff + 1'b1;
            cmp_valid_in = 1'b1;
            cmp_slot_in  = scan_addr_ff;
            if (cmp_valid_ff) begin
               if (slot_hit && !found_ff) begin
                  found_in      = 1'b1;
                  found_slot_in = cmp_slot_ff;
               end
               if (!slot_used && !free_ok_ff) begin
                  free_ok_in   = 1'b1;
                  free_slot_in = cmp_slot_ff;
               end
               if (scan_stop) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = kspa_pkg::ST_OK;
               rsp_slot_in    = '0;
               rsp_created_in = 1'b0;
               state_in       = ST_IDLE;
               case (op_ff)
                  kspa_pkg::OP_ALLOC: begin
                     if (free_ok_ff) begin
                        used_in[free_slot_ff] = 1'b1;
                        count_in       = count_ff + 1'b1;
                        mem_we         = 1'b1;
                        mem_wdata      = '0;
                        rsp_slot_in    = kspa_pkg::SLOT_W'(free_slot_ff);
                        rsp_created_in = 1'b1;
                     end else begin
                        rsp_status_in = kspa_pkg::ST_MISS;
                     end
                  end
                  kspa_pkg::OP_FREE: begin
                     if ({1'b0, index_ff} >= (kspa_pkg::SLOT_IN_W + 1)'(kspa_pkg::POOL_SLOTS))
                     begin
                        rsp_status_in = kspa_pkg::ST_RANGE;
                     end else begin
                        if (used_ff[free_idx]) begin
                           count_in = count_ff - 1'b1;
                        end
                        used_in[free_idx] = 1'b0;
                        rsp_slot_in = kspa_pkg::SLOT_W'(free_idx);
                     end
                  end
                  kspa_pkg::OP_FIND: begin
                     if (found_ff) begin
                        rsp_slot_in = kspa_pkg::SLOT_W'(found_slot_ff);
                     end else begin
                        rsp_status_in = kspa_pkg::ST_MISS;
                     end
                  end
                  kspa_pkg::OP_GET_CREATE: begin
                     if (found_ff) begin
                        rsp_slot_in = kspa_pkg::SLOT_W'(found_slot_ff);
                     end else if (free_ok_ff) begin
                        used_in[free_slot_ff] = 1'b1;
                        count_in       = count_ff + 1'b1;
                        mem_we         = 1'b1;
                        mem_wdata      = key_ff;
                        rsp_slot_in    = kspa_pkg::SLOT_W'(free_slot_ff);
                        rsp_created_in = 1'b1;
                     end else begin
                        rsp_status_in = kspa_pkg::ST_MISS;
                     end
                  end
                  kspa_pkg::OP_CLEAR: begin
                     used_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         free_ok_ff   <= free_ok_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      index_ff       <= index_in;
      scan_addr_ff   <= scan_addr_in;
      cmp_slot_ff    <= cmp_slot_in;
      found_slot_ff  <= found_slot_in;
      free_slot_ff   <= free_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_created_ff <= rsp_created_in;
   end

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
      rd_key_ff <= key_mem[scan_addr_ff];
   end

   // checks
   `KSPA_ASSERT_SAME(a_count_matches_used, clock, reset, 1'b1,
      $countones(used_ff) == 32'(count_ff), "used count differs from used bits")
   `KSPA_ASSERT_SAME(a_created_is_ok, clock, reset, rsp_valid_ff && rsp_created_ff,
      rsp_status_ff == kspa_pkg::ST_OK, "created item carries a failing status")
   `KSPA_ASSERT_SAME(a_fail_slot_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff != kspa_pkg::ST_OK),
      rsp_slot_ff == '0, "failing item carries a nonzero slot")
   `KSPA_ASSERT_NEXT(a_done_delivers, clock, reset, (state_ff == ST_DONE) && out_free,
      rsp_valid_ff && (state_ff == ST_IDLE), "finished item not loaded into output")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for keyed_slot_pool_allocator: directed and random item traffic
// depends on kspa_pkg and the keyed_slot_pool_allocator rtl
`timescale 1ns / 100ps

module tb;

   // codes with no operation behind them
   localparam logic [kspa_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [kspa_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   localparam int MAX_WAIT    = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int KEY_BANK_N  = 8;
   localparam int KEY_BANK_W  = $clog2(KEY_BANK_N);

   typedef struct packed {
      logic [kspa_pkg::OP_W-1:0]      op;
      logic [kspa_pkg::KEY_W-1:0]     key;
      logic [kspa_pkg::SLOT_IN_W-1:0] index;
   } pool_req_type;

   typedef struct packed {
      logic [kspa_pkg::STATUS_W-1:0] status;
      logic [kspa_pkg::SLOT_W-1:0]   slot;
      logic                          created;
      logic [kspa_pkg::COUNT_W-1:0]  count;
   } pool_rsp_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [kspa_pkg::OP_W-1:0]      req_operation = '0;
   logic [kspa_pkg::KEY_W-1:0]     req_key = '0;
   logic [kspa_pkg::SLOT_IN_W-1:0] req_slot_index = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [kspa_pkg::STATUS_W-1:0]  rsp_status;
   logic [kspa_pkg::SLOT_W-1:0]    rsp_slot;
   logic                           rsp_created;
   logic [kspa_pkg::COUNT_W-1:0]   rsp_used_count;

   // predicted pool contents
   logic                         slot_taken [kspa_pkg::POOL_SLOTS];
   logic [kspa_pkg::KEY_W-1:0]   slot_key_mem [kspa_pkg::POOL_SLOTS];
   logic [kspa_pkg::COUNT_W-1:0] taken_count;

   pool_rsp_type               pending_rsp_q [$];
   logic [kspa_pkg::KEY_W-1:0] key_bank [KEY_BANK_N];
   int                         fail_count = 0;
   int                         cycle_count = 0;
   int                         rsp_hold_draw = 0;
   int                         rsp_taken_n = 0;
   int                         rsp_seen_n = 0;
   int                         rsp_hold_left = 0;
   bit                         pace_on = 1'b1;

   keyed_slot_pool_allocator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_created      (rsp_created),
      .rsp_used_count   (rsp_used_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // lowest free slot, -1 when the pool is full
   function automatic int lowest_free();
      for (int i = 0; i < kspa_pkg::POOL_SLOTS; i++)
         if (!slot_taken[i]) return i;
      return -1;
   endfunction

   // lowest used slot holding the key, -1 on a miss
   function automatic int lowest_match(input logic [kspa_pkg::KEY_W-1:0] key);
      for (int i = 0; i < kspa_pkg::POOL_SLOTS; i++)
         if (slot_taken[i] && slot_key_mem[i] == key) return i;
      return -1;
   endfunction

   function automatic void empty_pool();
      for (int i = 0; i < kspa_pkg::POOL_SLOTS; i++) begin
         slot_taken[i]   = 1'b0;
         slot_key_mem[i] = '0;
      end
      taken_count = '0;
   endfunction

   // claim the lowest free slot for a key, -1 when none is left
   function automatic int claim_slot(input logic [kspa_pkg::KEY_W-1:0] key);
      int spot;
      spot = lowest_free();
      if (spot >= 0) begin
         slot_taken[spot]   = 1'b1;
         slot_key_mem[spot] = key;
         taken_count++;
      end
      return spot;
   endfunction

   // applies one item to the predicted pool and returns its result
   function automatic pool_rsp_type pool_outcome(input pool_req_type r);
      pool_rsp_type                 o;
      int                           spot;
      logic [kspa_pkg::IDX_W-1:0]   at;
      o = '0;
      o.status = kspa_pkg::ST_OK;
      at = r.index[kspa_pkg::IDX_W-1:0];
      case (r.op)
         kspa_pkg::OP_ALLOC: begin
            spot = claim_slot('0);
            if (spot < 0) o.status = kspa_pkg::ST_MISS;
            else begin
               o.slot    = spot[kspa_pkg::SLOT_W-1:0];
               o.created = 1'b1;
            end
         end
         kspa_pkg::OP_FREE: begin
            if (r.index >= kspa_pkg::POOL_SLOTS) o.status = kspa_pkg::ST_RANGE;
            else begin
               // only a used slot lowers the count
               if (slot_taken[at] && taken_count != 0) taken_count--;
               slot_taken[at]   = 1'b0;
               slot_key_mem[at] = '0;
               o.slot = r.index[kspa_pkg::SLOT_W-1:0];
            end
         end
         kspa_pkg::OP_FIND: begin
            spot = lowest_match(r.key);
            if (spot < 0) o.status = kspa_pkg::ST_MISS;
            else o.slot = spot[kspa_pkg::SLOT_W-1:0];
         end
         kspa_pkg::OP_GET_CREATE: begin
            spot = lowest_match(r.key);
            if (spot >= 0) o.slot = spot[kspa_pkg::SLOT_W-1:0];
            else begin
               spot = claim_slot(r.key);
               if (spot < 0) o.status = kspa_pkg::ST_MISS;
               else begin
                  o.slot    = spot[kspa_pkg::SLOT_W-1:0];
                  o.created = 1'b1;
               end
            end
         end
         kspa_pkg::OP_CLEAR: empty_pool();
         default: ;
      endcase
      o.count = taken_count;
      return o;
   endfunction

   function automatic logic [kspa_pkg::KEY_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // keys mostly from a small bank so that finds hit
   function automatic logic [kspa_pkg::KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return key_bank[KEY_BANK_W'($urandom_range(0, KEY_BANK_N - 1))];
      if (roll == 6) return '0;
      return random_key();
   endfunction

   // drive one item at the falling edge and hold it until accepted
   task automatic send_item(input logic [kspa_pkg::OP_W-1:0] op,
                            input logic [kspa_pkg::KEY_W-1:0] key,
                            input logic [kspa_pkg::SLOT_IN_W-1:0] index);
      pool_req_type r;
      int           gap;
      r.op    = op;
      r.key   = key;
      r.index = index;
      gap = pace_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_key        <= key;
      req_slot_index <= index;
      do @(posedge clock); while (req_stall);
      pending_rsp_q.push_back(pool_outcome(r));
      @(negedge clock);
   endtask

   // result check against the oldest expectation
   always @(posedge clock) begin
      pool_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            $error("result item with no expectation waiting");
            fail_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_slot !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_slot);
               fail_count++;
            end
            if (rsp_created !== want.created) begin
               $error("created: expected %0d, actual %0d", want.created, rsp_created);
               fail_count++;
            end
            if (rsp_used_count !== want.count) begin
               $error("used_count: expected %0d, actual %0d", want.count,
                      rsp_used_count);
               fail_count++;
            end
         end
         rsp_hold_draw = pace_on ? $urandom_range(0, MAX_WAIT) : 0;
         rsp_taken_n++;
      end
   end

   // receiver stall after each accepted result
   always @(negedge clock) begin
      if (rsp_taken_n != rsp_seen_n) begin
         rsp_seen_n    = rsp_taken_n;
         rsp_hold_left = rsp_hold_draw;
      end
      if (rsp_hold_left != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // allocate, find and get-or-create at the key extremes
   task automatic test_alloc_and_find();
      send_item(kspa_pkg::OP_ALLOC, random_key(), '1);
      send_item(kspa_pkg::OP_ALLOC, '0, '0);
      send_item(kspa_pkg::OP_FIND, '0, '0);     // zero key matches an allocated slot
      send_item(kspa_pkg::OP_GET_CREATE, '1, '0);
      send_item(kspa_pkg::OP_GET_CREATE, '1, '1);
      send_item(kspa_pkg::OP_FIND, '1, '0);
      send_item(kspa_pkg::OP_FIND, 64'h8000_0000_0000_0001, '0);   // key not found
   endtask

   // free of used, already free and out of range slots
   task automatic test_free_cases();
      send_item(kspa_pkg::OP_FREE, '0, 7'd0);
      send_item(kspa_pkg::OP_FREE, '1, 7'd0);      // slot already free
      send_item(kspa_pkg::OP_FREE, '0,
                kspa_pkg::SLOT_IN_W'(kspa_pkg::POOL_SLOTS - 1));
      send_item(kspa_pkg::OP_FREE, '0, kspa_pkg::SLOT_IN_W'(kspa_pkg::POOL_SLOTS));
      send_item(kspa_pkg::OP_FREE, '1, '1);
      send_item(kspa_pkg::OP_ALLOC, '0, '0);       // refills the freed slot
   endtask

   // clear and the codes that do nothing
   task automatic test_clear_and_spare_codes();
      send_item(kspa_pkg::OP_CLEAR, '1, '1);
      send_item(kspa_pkg::OP_FIND, '1, '0);
      for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
         send_item(c[kspa_pkg::OP_W-1:0], random_key(),
                   kspa_pkg::SLOT_IN_W'($urandom_range(0, 127)));
      send_item(kspa_pkg::OP_GET_CREATE, '0, '0);
   endtask

   // fill the pool and work on it while full
   task automatic test_pool_exhaustion();
      logic [kspa_pkg::KEY_W-1:0] held_key;
      held_key = '0;
      while (taken_count < kspa_pkg::POOL_SLOTS) begin
         held_key = random_key();
         send_item(kspa_pkg::OP_GET_CREATE, held_key,
                   kspa_pkg::SLOT_IN_W'($urandom_range(0, 127)));
      end
      send_item(kspa_pkg::OP_ALLOC, random_key(), '0);
      send_item(kspa_pkg::OP_GET_CREATE, random_key(), '0);
      send_item(kspa_pkg::OP_GET_CREATE, held_key, '0);
      send_item(kspa_pkg::OP_FIND, held_key, '0);
      repeat (4) begin
         send_item(kspa_pkg::OP_FREE, random_key(),
                   kspa_pkg::SLOT_IN_W'($urandom_range(0, kspa_pkg::POOL_SLOTS - 1)));
         send_item(kspa_pkg::OP_ALLOC, random_key(), '0);
      end
   endtask

   // mixed random traffic with stretches without pacing
   task automatic test_random_traffic(input int n_items, input int free_pct);
      int                             roll;
      logic [kspa_pkg::OP_W-1:0]      op;
      logic [kspa_pkg::KEY_W-1:0]     key;
      logic [kspa_pkg::SLOT_IN_W-1:0] index;
      for (int i = 0; i < KEY_BANK_N; i++) key_bank[i] = random_key();
      for (int n = 0; n < n_items; n++) begin
         if (n % 40 == 0) pace_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 19) == 0)
            key_bank[KEY_BANK_W'($urandom_range(0, KEY_BANK_N - 1))] = random_key();
         key   = pick_key();
         index = kspa_pkg::SLOT_IN_W'($urandom_range(0, 127));
         roll  = $urandom_range(0, 99);
         if (roll < free_pct) begin
            op = kspa_pkg::OP_FREE;
            if ($urandom_range(0, 6) != 0)
               index = kspa_pkg::SLOT_IN_W'($urandom_range(0, kspa_pkg::POOL_SLOTS - 1));
            key = random_key();
         end else if (roll < free_pct + 3) begin
            op = kspa_pkg::OP_CLEAR;
         end else if (roll < free_pct + 7) begin
            op = kspa_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end else begin
            case ($urandom_range(0, 2))
               0: op = kspa_pkg::OP_ALLOC;
               1: op = kspa_pkg::OP_FIND;
               default: op = kspa_pkg::OP_GET_CREATE;
            endcase
         end
         send_item(op, key, index);
      end
      pace_on = 1'b1;
   endtask

   initial begin
      empty_pool();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_alloc_and_find();
      test_free_cases();
      test_clear_and_spare_codes();
      test_pool_exhaustion();
      test_random_traffic(170, 35);
      test_random_traffic(170, 12);

      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (kspa_pkg::POOL_SLOTS + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
